// ----- hdl/cts_pkg.sv -----
// Shared types, constants and character helpers for the token scanner.
package cts_pkg;

  // Widths of the offset and length result fields
  localparam int unsigned TOKEN_POS_W = 16;
  // Default width of the internal position counter
  localparam int unsigned POSITION_BITS_DEF = 16;
  // Bundle slots per source byte: close, punctuator, final close, end
  localparam int unsigned SLOT_NUM = 4;
  // Bundle queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  // Keyword count and identifier length counter
  localparam int unsigned KW_NUM = 4;
  localparam int unsigned KW_CNT_W = 3;
  localparam logic [KW_CNT_W-1:0] KW_CNT_SAT = 3'd7;
  localparam logic [KW_CNT_W-1:0] KW_TEXT_LEN = 3'd6;

  // ASCII codes used by the classifier
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

  typedef enum logic [4:0] {
    KIND_NUM    = 5'd0,
    KIND_STR    = 5'd1,
    KIND_IDENT  = 5'd2,
    KIND_IF     = 5'd3,
    KIND_ELSE   = 5'd4,
    KIND_WHILE  = 5'd5,
    KIND_RETURN = 5'd6,
    KIND_PLUS   = 5'd7,
    KIND_MINUS  = 5'd8,
    KIND_STAR   = 5'd9,
    KIND_SLASH  = 5'd10,
    KIND_ASSIGN = 5'd11,
    KIND_SEMI   = 5'd12,
    KIND_LPAREN = 5'd13,
    KIND_RPAREN = 5'd14,
    KIND_LBRACE = 5'd15,
    KIND_RBRACE = 5'd16,
    KIND_COMMA  = 5'd17,
    KIND_END    = 5'd18
  } token_kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_NUM   = 2'd1,
    MODE_STR   = 2'd2,
    MODE_IDENT = 2'd3
  } scan_mode_e;

  // Input transaction
  typedef struct packed {
    logic [7:0] char_byte;
    logic       final_byte;
  } scan_in_t;

  // Result transaction
  typedef struct packed {
    token_kind_e            token_kind;
    logic [TOKEN_POS_W-1:0] token_start;
    logic [TOKEN_POS_W-1:0] token_length;
    logic                   run_end;
    logic                   position_overflow;
  } token_out_t;

  // One token candidate produced by the front
  typedef struct packed {
    token_kind_e            kind;
    logic [TOKEN_POS_W-1:0] start;
    logic [TOKEN_POS_W-1:0] length;
    logic                   ovf;
  } token_slot_t;

  // All tokens caused by one source byte
  typedef struct packed {
    logic [SLOT_NUM-1:0]      valid;
    token_slot_t [SLOT_NUM-1:0] slot;
  } token_bundle_t;

  // Queue status seen by the neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_ident_char(input logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
  endfunction

  // Punctuator lookup; KIND_END means the byte is not a punctuator
  function automatic token_kind_e punct_kind(input logic [7:0] c);
    token_kind_e k;
    case (c)
      "+":     k = KIND_PLUS;
      "-":     k = KIND_MINUS;
      "*":     k = KIND_STAR;
      "/":     k = KIND_SLASH;
      "=":     k = KIND_ASSIGN;
      ";":     k = KIND_SEMI;
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ",":     k = KIND_COMMA;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

  // Keyword text table, zero padded
  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [KW_CNT_W-1:0] idx);
    logic [7:0] ch;
    ch = 8'h00;
    case (k)
      2'd0: begin
        case (idx)
          3'd0:    ch = "i";
          3'd1:    ch = "f";
          default: ch = 8'h00;
        endcase
      end
      2'd1: begin
        case (idx)
          3'd0:    ch = "e";
          3'd1:    ch = "l";
          3'd2:    ch = "s";
          3'd3:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      2'd2: begin
        case (idx)
          3'd0:    ch = "w";
          3'd1:    ch = "h";
          3'd2:    ch = "i";
          3'd3:    ch = "l";
          3'd4:    ch = "e";
          default: ch = 8'h00;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    ch = "r";
          3'd1:    ch = "e";
          3'd2:    ch = "t";
          3'd3:    ch = "u";
          3'd4:    ch = "r";
          3'd5:    ch = "n";
          default: ch = 8'h00;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [KW_CNT_W-1:0] kw_len(input logic [1:0] k);
    logic [KW_CNT_W-1:0] len;
    case (k)
      2'd0:    len = 3'd2;
      2'd1:    len = 3'd4;
      2'd2:    len = 3'd5;
      default: len = 3'd6;
    endcase
    return len;
  endfunction

  function automatic token_kind_e kw_kind(input logic [1:0] k);
    token_kind_e kind;
    case (k)
      2'd0:    kind = KIND_IF;
      2'd1:    kind = KIND_ELSE;
      2'd2:    kind = KIND_WHILE;
      default: kind = KIND_RETURN;
    endcase
    return kind;
  endfunction

  // Identifier or keyword kind; the lowest matching keyword wins
  function automatic token_kind_e ident_kind(input logic [KW_NUM-1:0] cand,
                                             input logic [KW_CNT_W-1:0] cnt);
    token_kind_e kind;
    kind = KIND_IDENT;
    for (int k = KW_NUM - 1; k >= 0; k--) begin
      if (cand[k] && (kw_len(2'(k)) == cnt)) kind = kw_kind(2'(k));
    end
    return kind;
  endfunction

endpackage

// ----- hdl/c_like_token_scanner.sv -----
// Streaming scanner for a small C-like language: top level with front, queue and back.
// The accepting edge writes the bundle queue; the output register is loaded from its head.
// Throughput: one source byte per cycle unless full; one token per cycle while pop is held.
// A byte with several tokens (up to three) holds the queue head until its last one is loaded.
// The four-bundle queue absorbs such bursts; full rises only once it fills.
// Reset (rst_ni low, async): position zero, no open token, queue and output empty.
module c_like_token_scanner import cts_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  scan_in_t   in_data_i,
  output logic       empty,
  input  logic       pop,
  output token_out_t out_data_o
);

  logic          accept;
  logic          wr_en;
  token_bundle_t wr_bundle, head;
  queue_status_t q_status;
  logic          q_pop;

  assign full   = q_status.full;
  assign accept = push && !q_status.full;

  cts_front #(
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .accept_i      (accept),
    .in_data_i,
    .bundle_valid_o(wr_en),
    .bundle_o      (wr_bundle)
  );

  cts_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .wr_en_i  (wr_en),
    .wr_data_i(wr_bundle),
    .rd_en_i  (q_pop),
    .rd_data_o(head),
    .status_o (q_status)
  );

  cts_back u_back (
    .clk_i,
    .rst_ni,
    .head_i    (head),
    .q_status_i(q_status),
    .q_pop_o   (q_pop),
    .pop,
    .empty,
    .out_data_o
  );

  // The front never writes into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en |-> !q_status.full)
    else $error("bundle written while queue full");

  // End tokens are always last of their byte and carry no text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (out_data_o.token_kind == KIND_END)) |->
      (out_data_o.run_end && (out_data_o.token_length == '0)))
    else $error("malformed end token");

  // A waiting bundle reaches the empty output register in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_status.empty && empty) |=> !empty)
    else $error("output register not loaded from queue");

  // The queue is only drained while a bundle is present
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_status.empty)
    else $error("queue popped while empty");

endmodule

// ----- hdl/cts_front.sv -----
// Front end: classifies each source byte, tracks the open token, builds a token bundle.
module cts_front import cts_pkg::*; #(
  parameter int unsigned POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  scan_in_t      in_data_i,
  output logic          bundle_valid_o,
  output token_bundle_t bundle_o
);

  localparam int unsigned PW = POSITION_BITS;

  // Slot positions inside a bundle
  localparam int unsigned SLOT_CLOSE = 0;
  localparam int unsigned SLOT_PUNCT = 1;
  localparam int unsigned SLOT_FINAL = 2;
  localparam int unsigned SLOT_END   = 3;

  scan_mode_e          mode_q, mode_d, mode_mid;
  logic [PW-1:0]       begin_q, begin_d, begin_mid;
  logic [PW-1:0]       pos_q, pos_d;
  logic [KW_NUM-1:0]   cand_q, cand_d, cand_mid, cand_feed;
  logic [KW_CNT_W-1:0] cnt_q, cnt_d, cnt_mid, cnt_feed, feed_idx;
  logic                ovf_q, ovf_d;

  logic [7:0]  ch;
  logic        fin;
  logic        at_max;
  logic [PW-1:0] pos_next;
  logic        close_old, start_ident, feed_en, consumed;
  token_kind_e pk;
  token_kind_e close_kind;

  assign ch       = in_data_i.char_byte;
  assign fin      = in_data_i.final_byte;
  assign at_max   = (pos_q == {PW{1'b1}});
  assign pos_next = at_max ? pos_q : pos_q + PW'(1);
  assign pk       = punct_kind(ch);

  // Keyword matcher step for one identifier byte
  always_comb begin
    logic [KW_NUM-1:0] base;
    base     = start_ident ? {KW_NUM{1'b1}} : cand_q;
    feed_idx = start_ident ? '0 : cnt_q;
    cand_feed = base;
    if (feed_idx >= KW_TEXT_LEN) begin
      cand_feed = '0;
    end else begin
      for (int k = 0; k < KW_NUM; k++) begin
        if (kw_char(2'(k), feed_idx) != ch) cand_feed[k] = 1'b0;
      end
    end
    cnt_feed = (feed_idx < KW_CNT_SAT) ? feed_idx + KW_CNT_W'(1) : feed_idx;
  end

  // Scan state next value
  always_comb begin
    consumed    = 1'b0;
    close_old   = 1'b0;
    start_ident = 1'b0;
    feed_en     = 1'b0;
    mode_mid    = mode_q;
    begin_mid   = begin_q;
    close_kind  = KIND_NUM;
    case (mode_q)
      MODE_NUM: begin
        if (is_digit(ch)) consumed = 1'b1;
        else begin
          close_old = 1'b1;
          mode_mid  = MODE_IDLE;
        end
      end
      MODE_IDENT: begin
        close_kind = ident_kind(cand_q, cnt_q);
        if (is_ident_char(ch)) begin
          consumed = 1'b1;
          feed_en  = 1'b1;
        end else begin
          close_old = 1'b1;
          mode_mid  = MODE_IDLE;
        end
      end
      MODE_STR: begin
        close_kind = KIND_STR;
        consumed   = 1'b1;
        if (ch == CH_QUOTE) begin
          close_old = 1'b1;
          mode_mid  = MODE_IDLE;
        end
      end
      default: ;
    endcase
    // Opening a new token
    if (!consumed && !is_space(ch)) begin
      if (is_digit(ch)) begin
        mode_mid  = MODE_NUM;
        begin_mid = pos_q;
      end else if (is_alpha(ch) || (ch == CH_UNDERSCORE)) begin
        mode_mid    = MODE_IDENT;
        begin_mid   = pos_q;
        start_ident = 1'b1;
        feed_en     = 1'b1;
      end else if (ch == CH_QUOTE) begin
        mode_mid  = MODE_STR;
        begin_mid = pos_next;
      end
    end
    cand_mid = feed_en ? cand_feed : cand_q;
    cnt_mid  = feed_en ? cnt_feed : cnt_q;

    // Final byte returns everything to reset
    if (fin) begin
      mode_d  = MODE_IDLE;
      begin_d = '0;
      pos_d   = '0;
      cand_d  = {KW_NUM{1'b1}};
      cnt_d   = '0;
      ovf_d   = 1'b0;
    end else begin
      mode_d  = mode_mid;
      begin_d = begin_mid;
      pos_d   = pos_next;
      cand_d  = cand_mid;
      cnt_d   = cnt_mid;
      ovf_d   = ovf_q | at_max;
    end
  end

  // Token bundle for this byte
  always_comb begin
    logic ovf_fin;
    ovf_fin  = ovf_q | at_max;
    bundle_o = '0;

    bundle_o.valid[SLOT_CLOSE]       = close_old;
    bundle_o.slot[SLOT_CLOSE].kind   = close_kind;
    bundle_o.slot[SLOT_CLOSE].start  = TOKEN_POS_W'(begin_q);
    bundle_o.slot[SLOT_CLOSE].length = TOKEN_POS_W'(pos_q - begin_q);
    bundle_o.slot[SLOT_CLOSE].ovf    = ovf_q;

    bundle_o.valid[SLOT_PUNCT]       = !consumed && (pk != KIND_END);
    bundle_o.slot[SLOT_PUNCT].kind   = pk;
    bundle_o.slot[SLOT_PUNCT].start  = TOKEN_POS_W'(pos_q);
    bundle_o.slot[SLOT_PUNCT].length = TOKEN_POS_W'(1);
    bundle_o.slot[SLOT_PUNCT].ovf    = ovf_q;

    bundle_o.valid[SLOT_FINAL]       = fin && ((mode_mid == MODE_NUM) ||
                                               (mode_mid == MODE_IDENT));
    bundle_o.slot[SLOT_FINAL].kind   = (mode_mid == MODE_NUM) ? KIND_NUM
                                       : ident_kind(cand_mid, cnt_mid);
    bundle_o.slot[SLOT_FINAL].start  = TOKEN_POS_W'(begin_mid);
    bundle_o.slot[SLOT_FINAL].length = TOKEN_POS_W'(pos_next - begin_mid);
    bundle_o.slot[SLOT_FINAL].ovf    = ovf_fin;

    bundle_o.valid[SLOT_END]         = fin;
    bundle_o.slot[SLOT_END].kind     = KIND_END;
    bundle_o.slot[SLOT_END].start    = TOKEN_POS_W'(pos_next);
    bundle_o.slot[SLOT_END].length   = '0;
    bundle_o.slot[SLOT_END].ovf      = ovf_fin;
  end

  assign bundle_valid_o = accept_i && (|bundle_o.valid);

  // Scan state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      begin_q <= '0;
      pos_q   <= '0;
      cand_q  <= {KW_NUM{1'b1}};
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
      cand_q  <= cand_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ----- hdl/cts_queue.sv -----
// Bundle queue decoupling the front end from the token serializer.
module cts_queue import cts_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_en_i,
  input  token_bundle_t wr_data_i,
  input  logic          rd_en_i,
  output token_bundle_t rd_data_o,
  output queue_status_t status_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  token_bundle_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign status_o.full  = (cnt_q == CNT_W'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign do_wr = wr_en_i && !status_o.full;
  assign do_rd = rd_en_i && !status_o.empty;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = do_wr ? ((wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1)) : wr_ptr_q;
    rd_ptr_d = do_rd ? ((rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1)) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) cnt_d = cnt_q + CNT_W'(1);
    else if (!do_wr && do_rd) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// ----- hdl/cts_back.sv -----
// Back end: walks a bundle's valid slots; one token per cycle unless pop is low.
module cts_back import cts_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  token_bundle_t head_i,
  input  queue_status_t q_status_i,
  output logic          q_pop_o,
  input  logic          pop,
  output logic          empty,
  output token_out_t    out_data_o
);

  logic [SLOT_NUM-1:0] done_q, done_d;
  logic [SLOT_NUM-1:0] remain, sel, rest;
  logic                out_valid_q, out_valid_d;
  token_out_t          out_q, out_d;
  logic                load, taken;
  token_slot_t         pick;

  assign remain = head_i.valid & ~done_q;
  assign sel    = remain & (~remain + SLOT_NUM'(1));
  assign rest   = remain & ~sel;
  assign taken  = pop && out_valid_q;
  assign load   = !q_status_i.empty && (!out_valid_q || taken);
  assign q_pop_o = load && (rest == '0);

  // Slot select and next output
  always_comb begin
    pick = head_i.slot[0];
    for (int s = SLOT_NUM - 1; s >= 0; s--) begin
      if (sel[s]) pick = head_i.slot[s];
    end
    out_d.token_kind        = pick.kind;
    out_d.token_start       = pick.start;
    out_d.token_length      = pick.length;
    out_d.run_end           = (rest == '0);
    out_d.position_overflow = pick.ovf;

    done_d = done_q;
    if (load) done_d = (rest == '0) ? '0 : (done_q | sel);
    out_valid_d = load ? 1'b1 : (taken ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) out_q <= out_d;
  end

  assign empty      = !out_valid_q;
  assign out_data_o = out_q;

endmodule
